// ----- sv/lrk_pkg.sv -----
// Package: sizes, command codes, state codes and control structs for the run scanner.
`timescale 1ns / 1ps
`default_nettype none
package lrk_pkg;
	localparam int MAX_LEN = 2048;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int SYM_W   = 5;
	localparam int CHG_W   = 12;
	localparam int LEN_W   = 12;
	localparam int CMP_W   = (CNT_W > CHG_W) ? CNT_W : CHG_W;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		SC_IDLE   = 2'd0,
		SC_CHECK  = 2'd1,
		SC_UPDATE = 2'd2,
		SC_DONE   = 2'd3
	} scan_state_t;

	typedef struct packed {
		logic             start;
		logic [SYM_W-1:0] target;
		logic [CHG_W-1:0] budget;
		logic [CNT_W-1:0] length;
	} scan_req_t;

	typedef struct packed {
		logic             idle;
		logic             done;
		logic [CNT_W-1:0] best;
	} scan_stat_t;
endpackage
`default_nettype wire

// ----- sv/lrk_if.sv -----
// Interfaces: request channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface lrk_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [4:0]  symbol;
	logic [11:0] allowed_changes;
	logic [4:0]  target_letter;

	modport source (output valid, cmd, symbol, allowed_changes, target_letter, input ready);
	modport sink (input valid, cmd, symbol, allowed_changes, target_letter, output ready);
endinterface

interface lrk_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] best_length;
	logic        truncated;

	modport source (output valid, best_length, truncated, input ready);
	modport sink (input valid, best_length, truncated, output ready);
endinterface
`default_nettype wire

// ----- sv/longest_run_with_k_changes.sv -----
// Top level: command decode, string length and overflow state, result register.
//
//  channel  dir  payload                                         request
//  req      in   cmd, symbol, allowed_changes, target_letter     valid & ready
//  res      out  best_length, truncated                          valid & ready
//
// A query steps through the L stored symbols, each in a check state (registered
// read of both window ends) and then an update state, set by the single scan
// unit and the store's registered reads. req.ready is low while a query scans;
// a finished result waits in the scanner until the output register is free.
// Reset clears length, overflow, result valid and the scanner state.
`timescale 1ns / 1ps
`default_nettype none
module longest_run_with_k_changes
	import lrk_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	lrk_req_if.sink  req,
	lrk_res_if.source res
);
	logic [CNT_W-1:0]  len_q;
	logic              ovf_q;
	logic              res_valid_q;
	logic [LEN_W-1:0]  res_best_q;
	logic              res_trunc_q;
	logic              acc, full, take, we;
	scan_req_t         sreq;
	scan_stat_t        sstat;
	logic [ADDR_W-1:0] addr_hi, addr_lo;
	logic [SYM_W-1:0]  sym_hi, sym_lo;

	assign req.ready = sstat.idle;
	assign acc       = req.valid && req.ready;
	assign full      = len_q == CNT_W'(MAX_LEN);
	assign we        = acc && req.cmd == CMD_APPEND && !full;
	assign take      = sstat.done && (!res_valid_q || res.ready);

	assign sreq.start  = acc && req.cmd == CMD_QUERY;
	assign sreq.target = req.target_letter;
	assign sreq.budget = req.allowed_changes;
	assign sreq.length = len_q;

	lrk_store u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (len_q[ADDR_W-1:0]),
		.wdata   (req.symbol),
		.raddr_a (addr_hi),
		.raddr_b (addr_lo),
		.rdata_a (sym_hi),
		.rdata_b (sym_lo)
	);

	lrk_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sreq),
		.take    (take),
		.sym_hi  (sym_hi),
		.sym_lo  (sym_lo),
		.addr_hi (addr_hi),
		.addr_lo (addr_lo),
		.stat    (sstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (acc) begin
			if (req.cmd == CMD_APPEND) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + CNT_W'(1);
				end
			end else if (req.cmd == CMD_CLEAR) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_best_q  <= LEN_W'(sstat.best);
			res_trunc_q <= ovf_q;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.best_length = res_best_q;
	assign res.truncated   = res_trunc_q;

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(MAX_LEN)) else $error("stored length above capacity");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full) else $error("overflow flag set below capacity");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sreq.start |=> !req.ready) else $error("ready during query scan");
endmodule
`default_nettype wire

// ----- sv/lrk_store.sv -----
// Symbol memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module lrk_store
	import lrk_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [SYM_W-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [SYM_W-1:0]  rdata_a,
	output logic      [SYM_W-1:0]  rdata_b
);
	logic [SYM_W-1:0] mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

// ----- sv/lrk_scan.sv -----
// Window scanner: two pointers over the store; each step is a check, then an update.
`timescale 1ns / 1ps
`default_nettype none
module lrk_scan
	import lrk_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scan_req_t         req,
	input  wire logic              take,
	input  wire logic [SYM_W-1:0]  sym_hi,
	input  wire logic [SYM_W-1:0]  sym_lo,
	output logic      [ADDR_W-1:0] addr_hi,
	output logic      [ADDR_W-1:0] addr_lo,
	output scan_stat_t             stat
);
	scan_state_t      state_q, state_n;
	logic [CNT_W-1:0] hi_q, lo_q, miss_q, len_q, budget_q;
	logic [SYM_W-1:0] target_q;
	logic [CNT_W-1:0] miss_add, miss_n, lo_n, budget_sat;
	logic             over;

	// saturate allowed changes to the stored length
	assign budget_sat = (CMP_W'(req.budget) > CMP_W'(req.length)) ? req.length
		: CNT_W'(req.budget);

	assign addr_hi = hi_q[ADDR_W-1:0];
	assign addr_lo = lo_q[ADDR_W-1:0];

	always_comb begin
		miss_add = miss_q + CNT_W'(sym_hi != target_q);
		over     = miss_add > budget_q;
		miss_n   = over ? (miss_add - CNT_W'(sym_lo != target_q)) : miss_add;
		lo_n     = over ? (lo_q + CNT_W'(1)) : lo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q     <= '0;
			lo_q     <= '0;
			miss_q   <= '0;
			len_q    <= '0;
			budget_q <= '0;
			target_q <= '0;
		end else begin
			if (state_q == SC_IDLE && req.start) begin
				hi_q     <= '0;
				lo_q     <= '0;
				miss_q   <= '0;
				len_q    <= req.length;
				budget_q <= budget_sat;
				target_q <= req.target;
			end else if (state_q == SC_UPDATE) begin
				hi_q   <= hi_q + CNT_W'(1);
				lo_q   <= lo_n;
				miss_q <= miss_n;
			end
		end
	end

	always_comb begin
		state_n   = state_q;
		stat.idle = 1'b0;
		stat.done = 1'b0;
		stat.best = len_q - lo_q;
		case (state_q)
			SC_IDLE: begin
				stat.idle = 1'b1;
				if (req.start) begin
					state_n = SC_CHECK;
				end
			end
			SC_CHECK: begin
				state_n = (hi_q == len_q) ? SC_DONE : SC_UPDATE;
			end
			SC_UPDATE: begin
				state_n = SC_CHECK;
			end
			SC_DONE: begin
				stat.done = 1'b1;
				if (take) begin
					state_n = SC_IDLE;
				end
			end
			default: begin
				state_n = SC_IDLE;
			end
		endcase
	end

	a_lo_le_hi: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q) else $error("window start passed window end");
	a_hi_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != SC_IDLE |-> hi_q <= len_q) else $error("scan ran past stored length");
	a_miss_fit: assert property (@(posedge clk) disable iff (!arst_n)
		miss_q <= hi_q - lo_q) else $error("miss count exceeds window size");
	a_hi_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SC_UPDATE |=> hi_q == $past(hi_q) + CNT_W'(1))
		else $error("end pointer did not advance");
endmodule
`default_nettype wire
